### hdl/ppq_pkg.sv
package ppq_pkg;

  // Fraction bits of the coordinate format.
  localparam int unsigned FRAC = 16;
  // Fraction bits of the normal components.
  localparam int unsigned NRM_SHIFT = 30;
  // Quotient bits produced by the divider: the parameter with one extra fraction bit, before rounding and saturation.
  localparam int unsigned QB = 34;
  // Width of the dividend: residual magnitude with FRAC+1 fraction bits appended.
  localparam int unsigned NW = 64 + FRAC + 1;
  // Integer quotient above 2^OVF_SH always saturates.
  localparam int unsigned OVF_SH = 31 - FRAC;
  localparam int unsigned KW = 64 + OVF_SH + 1;

  localparam logic signed [31:0] NRM_MAX = 32'sd1073741824;
  localparam logic signed [31:0] NRM_MIN = -32'sd1073741824;
  localparam logic [64:0] HALF_LSB = 65'd536870912;

  typedef enum logic [2:0] {
    REG_NA = 3'd0,
    REG_NB = 3'd1,
    REG_NC = 3'd2,
    REG_OD = 3'd3,
    REG_PV = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FUNC_POINT = 1'b0,
    FUNC_LINE  = 1'b1
  } func_e;

  // Point query results, lowest field last so that the packing matches the bus.
  typedef struct packed {
    logic [31:0] mirror_z;
    logic [31:0] mirror_y;
    logic [31:0] mirror_x;
    logic [31:0] proj_z;
    logic [31:0] proj_y;
    logic [31:0] proj_x;
    logic [1:0]  side_sign;
    logic [30:0] distance;
  } pt_res_t;

  typedef struct packed {
    logic go;   // a real division whose result is reported
    logic ovf;  // quotient known to saturate
    logic neg;  // result is negative
  } div_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    logic [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -42'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/ppq_div.sv
module ppq_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  ppq_pkg::pt_res_t          in_pt_i,
  input  ppq_pkg::div_ctl_t         in_ctl_i,
  input  logic [ppq_pkg::NW-1:0]    in_num_i,
  input  logic [63:0]               in_dmag_i,
  output logic                      out_valid_o,
  output ppq_pkg::pt_res_t          out_pt_o,
  output logic [31:0]               out_t_o,
  output logic                      out_hit_o
);
  import ppq_pkg::*;

  // Entry k holds what step k sees; entry 0 is the input, entry k+1 the registers of step k.
  logic            p_vld [QB+1];
  pt_res_t         p_pt  [QB+1];
  div_ctl_t        p_ctl [QB+1];
  logic [63:0]     p_rem [QB+1];
  logic [QB-1:0]   p_quo [QB+1];
  logic [QB-1:0]   p_nlo [QB+1];
  logic [63:0]     p_dm  [QB+1];

  logic            vld_q [QB];
  pt_res_t         pt_q  [QB];
  div_ctl_t        ctl_q [QB];
  logic [63:0]     rem_q [QB];
  logic [QB-1:0]   quo_q [QB];
  logic [QB-1:0]   nlo_q [QB];
  logic [63:0]     dm_q  [QB];

  assign p_vld[0] = in_valid_i;
  assign p_pt[0]  = in_pt_i;
  assign p_ctl[0] = in_ctl_i;
  assign p_rem[0] = 64'(in_num_i[NW-1:QB]);
  assign p_quo[0] = '0;
  assign p_nlo[0] = in_num_i[QB-1:0];
  assign p_dm[0]  = in_dmag_i;

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [64:0]   trial;
    logic          ge;
    logic [63:0]   rem_d;
    logic [QB-1:0] quo_d;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb begin
      trial = {p_rem[k], p_nlo[k][QB-1-k]};
      ge    = trial >= {1'b0, p_dm[k]};
      rem_d = ge ? 64'(trial - {1'b0, p_dm[k]}) : trial[63:0];
      quo_d = {p_quo[k][QB-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pt_q[k]  <= p_pt[k];
        ctl_q[k] <= p_ctl[k];
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        nlo_q[k] <= p_nlo[k];
        dm_q[k]  <= p_dm[k];
      end
    end

    assign p_vld[k+1] = vld_q[k];
    assign p_pt[k+1]  = pt_q[k];
    assign p_ctl[k+1] = ctl_q[k];
    assign p_rem[k+1] = rem_q[k];
    assign p_quo[k+1] = quo_q[k];
    assign p_nlo[k+1] = nlo_q[k];
    assign p_dm[k+1]  = dm_q[k];
  end

  logic [34:0]        mag;
  logic signed [41:0] tsgn;
  logic [31:0]        t_d;
  logic               out_vld_q;
  pt_res_t            out_pt_q;
  logic [31:0]        out_t_q;
  logic               out_hit_q;

  // The quotient carries one extra fraction bit, which rounds half away from zero.
  always_comb begin
    mag  = p_ctl[QB].ovf ? 35'h1_0000_0000 : 35'(({1'b0, p_quo[QB]} + 35'd1) >> 1);
    tsgn = p_ctl[QB].neg ? -$signed(42'(mag)) : $signed(42'(mag));
    t_d  = p_ctl[QB].go ? sat32(tsgn) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= p_vld[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_pt_q  <= p_pt[QB];
      out_t_q   <= t_d;
      out_hit_q <= p_ctl[QB].go;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_pt_o    = out_pt_q;
  assign out_t_o     = out_t_q;
  assign out_hit_o   = out_hit_q;

endmodule

### hdl/point_plane_query_unit.sv
// Channel   Direction  Payload
// s_axis    in         tdata: px, py, pz, qx, qy, qz (32 bits each); tuser: func
// m_axis    out        tdata: distance, side_sign, proj_x/y/z, mirror_x/y/z, line_t, hit
// cfg       in         cfg_addr_i: register index, cfg_data_i: value; always ready
//
// One item is accepted per cycle while the output beat is not held; each passes six
// stages of products, sums and rounding, then one stage per quotient bit of the
// 34-step restoring divider, then the output register.
// Reset clears all valid bits and the plane registers; no clearing pass is needed.
// When the output beat is held, the whole pipeline holds with it and tready falls.
module point_plane_query_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // px, py, pz, qx, qy, qz
  input  logic         s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance, side_sign, proj_x, proj_y, proj_z, mirror_x, mirror_y, mirror_z, line_t,
  // hit, zero fill
  output logic [263:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);
  import ppq_pkg::*;

  logic en;

  // Plane registers; normals are stored already clamped to unit range.
  logic signed [31:0] n_q [3];
  logic signed [31:0] od_q;
  logic               pv_q;
  logic signed [31:0] ncl;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if ($signed(cfg_data_i) > NRM_MAX) begin
      ncl = NRM_MAX;
    end else if ($signed(cfg_data_i) < NRM_MIN) begin
      ncl = NRM_MIN;
    end else begin
      ncl = $signed(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q[0] <= '0;
      n_q[1] <= '0;
      n_q[2] <= '0;
      od_q   <= '0;
      pv_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_NA:  n_q[0] <= ncl;
        REG_NB:  n_q[1] <= ncl;
        REG_NC:  n_q[2] <= ncl;
        REG_OD:  od_q   <= $signed(cfg_data_i);
        REG_PV:  pv_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: capture the beat and form the segment direction.
  logic               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  func_e              f1_q, f2_q, f3_q, f4_q, f5_q;
  logic signed [31:0] p1_q [3];
  logic signed [31:0] p2_q [3];
  logic signed [31:0] p3_q [3];
  logic signed [31:0] p4_q [3];
  logic signed [31:0] p5_q [3];
  logic signed [32:0] dif1_d [3];
  logic signed [32:0] dif1_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif1_d[i] = 33'(signed'(s_axis_tdata[32*i +: 32]))
                - 33'(signed'(s_axis_tdata[96 + 32*i +: 32]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Stage 2: products of the normal with the point and with the direction.
  logic signed [63:0] prd2_d [3];
  logic signed [63:0] prd2_q [3];
  logic signed [64:0] dpr2_d [3];
  logic signed [64:0] dpr2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prd2_d[i] = 64'(n_q[i]) * 64'(p1_q[i]);
      dpr2_d[i] = 65'(n_q[i]) * 65'(dif1_q[i]);
    end
  end

  // Stage 3: exact residual and denominator.
  logic signed [65:0] dterm;
  logic signed [65:0] r3_d, r3_q;
  logic signed [66:0] den3_d, den3_q;

  always_comb begin
    dterm  = $signed({{4{od_q[31]}}, od_q, 30'd0});
    r3_d   = 66'(prd2_q[0]) + 66'(prd2_q[1]) + 66'(prd2_q[2]) - dterm;
    den3_d = 67'(dpr2_q[0]) + 67'(dpr2_q[1]) + 67'(dpr2_q[2]);
  end

  // Stage 4: signs, magnitudes and the rounded distance.
  logic signed [65:0] rabs;
  logic signed [66:0] dabs;
  logic [64:0]        efull;
  logic               rneg4_d, rneg4_q, dnz4_d, dnz4_q, dneg4_q;
  logic [1:0]         side4_d, side4_q;
  logic [63:0]        rmag4_q, dmag4_q;
  logic [34:0]        emag4_q;
  logic [30:0]        dist4_d, dist4_q;

  always_comb begin
    rneg4_d = r3_q[65];
    rabs    = rneg4_d ? -r3_q : r3_q;
    dabs    = den3_q[66] ? -den3_q : den3_q;
    dnz4_d  = den3_q != '0;
    if (r3_q == '0) begin
      side4_d = 2'b00;
    end else if (rneg4_d) begin
      side4_d = 2'b11;
    end else begin
      side4_d = 2'b01;
    end
    efull   = {1'b0, rabs[63:0]} + HALF_LSB;
    dist4_d = (efull[64:30] > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : efull[60:30];
  end

  // Stage 5: offset products and the saturation test of the quotient.
  logic [30:0]        nmag [3];
  logic [65:0]        offm5_d [3];
  logic [65:0]        offm5_q [3];
  logic [KW-1:0]      dk;
  logic               ovf5_d, ovf5_q;
  logic               rneg5_q, dnz5_q, dneg5_q;
  logic [1:0]         side5_q;
  logic [30:0]        dist5_q;
  logic [63:0]        rmag5_q, dmag5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i]    = n_q[i][31] ? 31'(-n_q[i]) : n_q[i][30:0];
      offm5_d[i] = 66'(nmag[i]) * 66'(emag4_q);
    end
    dk     = (KW'(dmag4_q) << OVF_SH) + KW'(dmag4_q);
    ovf5_d = KW'(rmag4_q) >= dk;
  end

  // Stage 6: projection and mirror, and the divider set-up.
  logic [65:0]        offr [3];
  logic signed [41:0] soff [3];
  logic [31:0]        prj [3];
  logic [31:0]        mir [3];
  pt_res_t            pt6_d, pt6_q;
  div_ctl_t           ctl6_d, ctl6_q;
  logic [NW-1:0]      num6_q;
  logic [63:0]        dmag6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      offr[i] = offm5_q[i] + 66'(HALF_LSB);
      soff[i] = (rneg5_q ^ n_q[i][31]) ? -$signed(42'(offr[i][65:30]))
                                       : $signed(42'(offr[i][65:30]));
      prj[i]  = sat32(42'(p5_q[i]) - soff[i]);
      mir[i]  = pv_q ? sat32(42'(p5_q[i]) - (soff[i] <<< 1)) : p5_q[i];
    end
    if (f5_q == FUNC_POINT) begin
      pt6_d.distance  = dist5_q;
      pt6_d.side_sign = side5_q;
      pt6_d.proj_x    = prj[0];
      pt6_d.proj_y    = prj[1];
      pt6_d.proj_z    = prj[2];
      pt6_d.mirror_x  = mir[0];
      pt6_d.mirror_y  = mir[1];
      pt6_d.mirror_z  = mir[2];
    end else begin
      pt6_d = '0;
    end
    ctl6_d.go  = (f5_q == FUNC_LINE) && pv_q && dnz5_q;
    ctl6_d.ovf = ovf5_q;
    ctl6_d.neg = rneg5_q ^ dneg5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q    <= func_e'(s_axis_tuser);
      f2_q    <= f1_q;
      f3_q    <= f2_q;
      f4_q    <= f3_q;
      f5_q    <= f4_q;
      for (int i = 0; i < 3; i++) begin
        p1_q[i]    <= signed'(s_axis_tdata[32*i +: 32]);
        p2_q[i]    <= p1_q[i];
        p3_q[i]    <= p2_q[i];
        p4_q[i]    <= p3_q[i];
        p5_q[i]    <= p4_q[i];
        dif1_q[i]  <= dif1_d[i];
        prd2_q[i]  <= prd2_d[i];
        dpr2_q[i]  <= dpr2_d[i];
        offm5_q[i] <= offm5_d[i];
      end
      r3_q    <= r3_d;
      den3_q  <= den3_d;
      rneg4_q <= rneg4_d;
      dnz4_q  <= dnz4_d;
      dneg4_q <= den3_q[66];
      side4_q <= side4_d;
      rmag4_q <= rabs[63:0];
      dmag4_q <= dabs[63:0];
      emag4_q <= efull[64:30];
      dist4_q <= dist4_d;
      rneg5_q <= rneg4_q;
      dnz5_q  <= dnz4_q;
      dneg5_q <= dneg4_q;
      side5_q <= side4_q;
      dist5_q <= dist4_q;
      rmag5_q <= rmag4_q;
      dmag5_q <= dmag4_q;
      ovf5_q  <= ovf5_d;
      pt6_q   <= pt6_d;
      ctl6_q  <= ctl6_d;
      num6_q  <= {rmag5_q, (FRAC + 1)'(0)};
      dmag6_q <= dmag5_q;
    end
  end

  pt_res_t     out_pt;
  logic [31:0] out_t;
  logic        out_hit;

  ppq_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (v6_q),
    .in_pt_i     (pt6_q),
    .in_ctl_i    (ctl6_q),
    .in_num_i    (num6_q),
    .in_dmag_i   (dmag6_q),
    .out_valid_o (m_axis_tvalid),
    .out_pt_o    (out_pt),
    .out_t_o     (out_t),
    .out_hit_o   (out_hit)
  );

  assign m_axis_tdata = {6'd0, out_hit, out_t, out_pt};

endmodule

### hdl/ppq_checker.sv
module ppq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [191:0] s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [263:0] m_axis_tdata,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [2:0]   cfg_addr_i,
  input logic [31:0]  cfg_data_i
);

  // A held result beat keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // An empty output stage never blocks the input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A hit belongs to a segment query, whose point fields are zero.
  a_hit_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[257] |-> m_axis_tdata[224:0] == '0)
    else $error("hit with point fields set");

  // Without a hit the parameter is zero.
  a_nohit_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[257] |-> m_axis_tdata[256:225] == '0)
    else $error("parameter set without a hit");

  // The side code is never the unused pattern.
  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32:31] != 2'b10)
    else $error("bad side code");

endmodule

bind point_plane_query_unit ppq_checker u_ppq_checker (.*);
